// ===== rtl/core/mono_bitblt_xnor_unit_macros.svh =====
// Assertion helpers for the monochrome blit unit.
`ifndef MONO_BITBLT_XNOR_UNIT_MACROS_SVH
`define MONO_BITBLT_XNOR_UNIT_MACROS_SVH

// Clocked, reset-gated implication check.
`define MBX_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mbx check failed");

// Same, for a signal that must hold its value while a condition is true.
`define MBX_ASSERT_HOLD(label, clk, rst_n, cond, sig) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (cond) |=> $stable(sig)) else $error("mbx hold check failed");

`endif

// ===== rtl/core/mbx_pkg.sv =====
package mbx_pkg;

  localparam int unsigned WORD_W           = 16;
  localparam int unsigned DEF_ADDRESS_BITS = 24;
  localparam int unsigned OUT_ADDR_W       = 24;
  localparam int unsigned SPAN_W           = 13;
  localparam int unsigned COL_W            = 9;
  localparam int unsigned ROW_W            = 12;
  localparam int unsigned CFG_DATA_W       = 24;
  localparam int unsigned CFG_IDX_W        = 3;

  localparam logic [WORD_W-1:0] WORD_ONES = 16'hFFFF;
  localparam logic [SPAN_W-1:0] SPAN_MAX  = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_BIT_OFFSET  = 3'd0,
    CFG_DST_X           = 3'd1,
    CFG_DST_Y           = 3'd2,
    CFG_WIDTH_PIXELS    = 3'd3,
    CFG_HEIGHT_ROWS     = 3'd4,
    CFG_DST_PITCH_WORDS = 3'd5,
    CFG_DST_BASE_WORD   = 3'd6,
    CFG_REVERSE         = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0]  src_bit_offset;
    logic [11:0] dst_x;
    logic [11:0] dst_y;
    logic [12:0] width_pixels;
    logic [12:0] height_rows;
    logic [12:0] dst_pitch_words;
    logic [23:0] dst_base_word;
    logic        reverse;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] old_dest;
    logic [WORD_W-1:0] src_upper;
    logic [WORD_W-1:0] src_lower;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]     new_dest;
    logic [OUT_ADDR_W-1:0] dest_word_address;
    logic                  last_in_row;
    logic                  last_in_blit;
  } out_item_t;

  // Position of the current word within the rectangle.
  typedef struct packed {
    logic       row_end;
    logic       blit_end;
    logic       left_edge;
    logic       right_edge;
    logic [3:0] right_bit;
  } pos_t;

endpackage

// ===== rtl/core/mbx_cfg_regs.sv =====
module mbx_cfg_regs
  import mbx_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_bit_offset  <= '0;
      cfg_q.dst_x           <= '0;
      cfg_q.dst_y           <= '0;
      cfg_q.width_pixels    <= 13'd1;
      cfg_q.height_rows     <= 13'd1;
      cfg_q.dst_pitch_words <= 13'd1;
      cfg_q.dst_base_word   <= '0;
      cfg_q.reverse         <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SRC_BIT_OFFSET:  cfg_q.src_bit_offset  <= cfg_data_i[3:0];
        CFG_DST_X:           cfg_q.dst_x           <= cfg_data_i[11:0];
        CFG_DST_Y:           cfg_q.dst_y           <= cfg_data_i[11:0];
        CFG_WIDTH_PIXELS:    cfg_q.width_pixels    <= cfg_data_i[12:0];
        CFG_HEIGHT_ROWS:     cfg_q.height_rows     <= cfg_data_i[12:0];
        CFG_DST_PITCH_WORDS: cfg_q.dst_pitch_words <= cfg_data_i[12:0];
        CFG_DST_BASE_WORD:   cfg_q.dst_base_word   <= cfg_data_i[23:0];
        CFG_REVERSE:         cfg_q.reverse         <= cfg_data_i[0];
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/mbx_walk.sv =====
module mbx_walk
  import mbx_pkg::*;
#(
  parameter int unsigned ADDRESS_BITS = DEF_ADDRESS_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    step_i,
  output logic [ADDRESS_BITS-1:0] addr_o,
  output pos_t                    pos_o
);

  localparam int unsigned SumW = 33;

  function automatic logic [SPAN_W-1:0] clamp_span(input logic [SPAN_W-1:0] v);
    logic [SPAN_W-1:0] r;
    if (v == '0) begin
      r = SPAN_W'(1);
    end else if (v > SPAN_MAX) begin
      r = SPAN_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [COL_W-1:0]        word_column_q, word_column_d;
  logic [ROW_W-1:0]        row_count_q, row_count_d;
  logic [ADDRESS_BITS-1:0] row_start_q, row_start_d;
  logic [ADDRESS_BITS-1:0] word_address_q, word_address_d;

  logic [SPAN_W-1:0]       w, h, dx_end, y_term;
  logic [SPAN_W:0]         words_sum;
  logic [COL_W-1:0]        words, x_word;
  logic [2*SPAN_W-1:0]     product;
  logic [SumW-1:0]         start_sum;
  logic [ADDRESS_BITS-1:0] start_addr, cur_addr, cur_row_start, next_row_start;
  logic                    first, row_end, blit_end;

  always_comb begin
    w         = clamp_span(cfg_i.width_pixels);
    h         = clamp_span(cfg_i.height_rows);
    dx_end    = SPAN_W'(cfg_i.dst_x) + w - SPAN_W'(1);
    words_sum = (SPAN_W + 1)'(cfg_i.dst_x[3:0]) + (SPAN_W + 1)'(w) + (SPAN_W + 1)'(15);
    // at most 257 words, the top bit of the sum is always clear
    words     = words_sum[COL_W+3:4];

    // One shared multiplier for both walk directions.
    y_term    = cfg_i.reverse ? (SPAN_W'(cfg_i.dst_y) + h - SPAN_W'(1))
                              : SPAN_W'(cfg_i.dst_y);
    x_word    = cfg_i.reverse ? dx_end[SPAN_W-1:4] : COL_W'(cfg_i.dst_x[11:4]);
    product   = y_term * cfg_i.dst_pitch_words;
    start_sum = SumW'(cfg_i.dst_base_word) + SumW'(product) + SumW'(x_word);
    start_addr = ADDRESS_BITS'(start_sum);

    first         = (word_column_q == '0) && (row_count_q == '0);
    cur_addr      = first ? start_addr : word_address_q;
    cur_row_start = first ? start_addr : row_start_q;

    row_end  = ((COL_W + 1)'(word_column_q) + (COL_W + 1)'(1)) >= (COL_W + 1)'(words);
    blit_end = row_end &&
               (((SPAN_W)'(row_count_q) + SPAN_W'(1)) >= h);

    pos_o.row_end    = row_end;
    pos_o.blit_end   = blit_end;
    pos_o.left_edge  = cfg_i.reverse ? row_end : (word_column_q == '0);
    pos_o.right_edge = cfg_i.reverse ? (word_column_q == '0) : row_end;
    pos_o.right_bit  = dx_end[3:0];
    addr_o           = cur_addr;

    next_row_start = cfg_i.reverse
                   ? cur_row_start - ADDRESS_BITS'(cfg_i.dst_pitch_words)
                   : cur_row_start + ADDRESS_BITS'(cfg_i.dst_pitch_words);

    word_column_d  = word_column_q;
    row_count_d    = row_count_q;
    row_start_d    = row_start_q;
    word_address_d = word_address_q;
    if (step_i) begin
      priority if (blit_end) begin
        word_column_d  = '0;
        row_count_d    = '0;
        row_start_d    = '0;
        word_address_d = '0;
      end else if (row_end) begin
        word_column_d  = '0;
        row_count_d    = row_count_q + ROW_W'(1);
        row_start_d    = next_row_start;
        word_address_d = next_row_start;
      end else begin
        word_column_d  = word_column_q + COL_W'(1);
        row_start_d    = cur_row_start;
        word_address_d = cfg_i.reverse ? cur_addr - ADDRESS_BITS'(1)
                                       : cur_addr + ADDRESS_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_column_q  <= '0;
      row_count_q    <= '0;
      row_start_q    <= '0;
      word_address_q <= '0;
    end else begin
      word_column_q  <= word_column_d;
      row_count_q    <= row_count_d;
      row_start_q    <= row_start_d;
      word_address_q <= word_address_d;
    end
  end

endmodule

// ===== rtl/core/mbx_rop.sv =====
module mbx_rop
  import mbx_pkg::*;
(
  input  cfg_t              cfg_i,
  input  pos_t              pos_i,
  input  in_item_t          item_i,
  output logic [WORD_W-1:0] new_dest_o
);

  logic [3:0]          dxo, k;
  logic [2*WORD_W-1:0] funnel;
  logic [WORD_W-1:0]   aligned, mask;

  always_comb begin
    dxo     = cfg_i.dst_x[3:0];
    k       = cfg_i.src_bit_offset - dxo;
    funnel  = {item_i.src_upper, item_i.src_lower} << k;
    aligned = funnel[2*WORD_W-1:WORD_W];

    mask = WORD_ONES;
    if (pos_i.left_edge) begin
      mask = mask & (WORD_ONES >> dxo);
    end
    if (pos_i.right_edge) begin
      mask = mask & WORD_W'(WORD_ONES << (4'd15 - pos_i.right_bit));
    end

    new_dest_o = (item_i.old_dest & ~mask) | (~(aligned ^ item_i.old_dest) & mask);
  end

endmodule

// ===== rtl/core/mono_bitblt_xnor_unit.sv =====
// Channel  Dir  Handshake             Payload
// in       in   in_valid_i/in_stall_o   in_data_i   (old_dest, src_upper, src_lower)
// out      out  out_valid_o/out_stall_i out_data_o  (new_dest, address, row/blit flags)
// cfg      in   cfg_we_i                cfg_index_i, cfg_data_i
//
// One transaction per cycle sustained while out_stall_i is low; the path runs from
// the input register through the shift/mask/address stage into the result register.
// Reset clears the walk position, all valid flags and loads the register defaults.
// A stalled result holds; the input register keeps accepting while it is empty
// or moving forward.
module mono_bitblt_xnor_unit
  import mbx_pkg::*;
#(
  parameter int unsigned ADDRESS_BITS = DEF_ADDRESS_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o
);

  cfg_t                    cfg;
  pos_t                    pos;
  logic [ADDRESS_BITS-1:0] addr;
  logic [WORD_W-1:0]       new_dest;

  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  logic      out_valid_q;
  logic      advance, step;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign step       = in_valid_q && advance;

  mbx_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mbx_walk #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .addr_o (addr),
    .pos_o  (pos)
  );

  mbx_rop u_rop (
    .cfg_i      (cfg),
    .pos_i      (pos),
    .item_i     (in_q),
    .new_dest_o (new_dest)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q.new_dest          <= new_dest;
      out_q.dest_word_address <= OUT_ADDR_W'(addr);
      out_q.last_in_row       <= pos.row_end;
      out_q.last_in_blit      <= pos.blit_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/mbx_checker.sv =====
`include "mono_bitblt_xnor_unit_macros.svh"

module mbx_checker
  import mbx_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input out_item_t             out_data_o
);

  // Stalled result transaction stays offered and unchanged.
  `MBX_ASSERT(a_out_valid_holds, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o)
  `MBX_ASSERT_HOLD(a_out_data_holds, clk_i, rst_ni, out_valid_o && out_stall_i, out_data_o)

  // The end of the rectangle is always the end of a row.
  `MBX_ASSERT(a_blit_end_is_row_end, clk_i, rst_ni, out_valid_o && out_data_o.last_in_blit |-> out_data_o.last_in_row)

  // With the result register empty, nothing can back up into the input.
  `MBX_ASSERT(a_no_stall_when_empty, clk_i, rst_ni, !out_valid_o |-> !in_stall_o)

endmodule

bind mono_bitblt_xnor_unit mbx_checker u_mbx_checker (.*);
